>>> rtl/ps2sc_pkg.sv
// Shared types, key codes and ASCII lookup tables for the PS/2 scancode decoder.
package ps2sc_pkg;

    typedef enum logic [1:0] {
        CMD_SCANCODE = 2'd0,
        CMD_POP      = 2'd1,
        CMD_FLUSH    = 2'd2,
        CMD_REINIT   = 2'd3
    } cmd_t;

    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;

    // Depth of the output word queue behind the memory read stage.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef struct packed {
        logic [6:0] character;
        logic       char_valid;
        logic       buffer_empty;
        logic       buffer_full;
        logic       push_dropped;
        logic       shift_active;
        logic       caps_active;
    } result_t;

    // Unshifted set-1 key map; zero means the key produces no character.
    function automatic logic [6:0] plain_char(input logic [6:0] key);
        logic [6:0] c;
        begin
            case (key)
                7'h01: c = 7'h1B;
                7'h02: c = 7'h31;
                7'h03: c = 7'h32;
                7'h04: c = 7'h33;
                7'h05: c = 7'h34;
                7'h06: c = 7'h35;
                7'h07: c = 7'h36;
                7'h08: c = 7'h37;
                7'h09: c = 7'h38;
                7'h0A: c = 7'h39;
                7'h0B: c = 7'h30;
                7'h0C: c = 7'h2D;
                7'h0D: c = 7'h3D;
                7'h0E: c = 7'h08;
                7'h0F: c = 7'h09;
                7'h10: c = 7'h71;
                7'h11: c = 7'h77;
                7'h12: c = 7'h65;
                7'h13: c = 7'h72;
                7'h14: c = 7'h74;
                7'h15: c = 7'h79;
                7'h16: c = 7'h75;
                7'h17: c = 7'h69;
                7'h18: c = 7'h6F;
                7'h19: c = 7'h70;
                7'h1A: c = 7'h5B;
                7'h1B: c = 7'h5D;
                7'h1C: c = 7'h0A;
                7'h1E: c = 7'h61;
                7'h1F: c = 7'h73;
                7'h20: c = 7'h64;
                7'h21: c = 7'h66;
                7'h22: c = 7'h67;
                7'h23: c = 7'h68;
                7'h24: c = 7'h6A;
                7'h25: c = 7'h6B;
                7'h26: c = 7'h6C;
                7'h27: c = 7'h3B;
                7'h28: c = 7'h27;
                7'h29: c = 7'h60;
                7'h2B: c = 7'h5C;
                7'h2C: c = 7'h7A;
                7'h2D: c = 7'h78;
                7'h2E: c = 7'h63;
                7'h2F: c = 7'h76;
                7'h30: c = 7'h62;
                7'h31: c = 7'h6E;
                7'h32: c = 7'h6D;
                7'h33: c = 7'h2C;
                7'h34: c = 7'h2E;
                7'h35: c = 7'h2F;
                7'h37: c = 7'h2A;
                7'h39: c = 7'h20;
                default: c = 7'h00;
            endcase
            return c;
        end
    endfunction

    // Shifted set-1 key map.
    function automatic logic [6:0] shift_char(input logic [6:0] key);
        logic [6:0] c;
        begin
            case (key)
                7'h01: c = 7'h1B;
                7'h02: c = 7'h21;
                7'h03: c = 7'h40;
                7'h04: c = 7'h23;
                7'h05: c = 7'h24;
                7'h06: c = 7'h25;
                7'h07: c = 7'h5E;
                7'h08: c = 7'h26;
                7'h09: c = 7'h2A;
                7'h0A: c = 7'h28;
                7'h0B: c = 7'h29;
                7'h0C: c = 7'h5F;
                7'h0D: c = 7'h2B;
                7'h0E: c = 7'h08;
                7'h0F: c = 7'h09;
                7'h10: c = 7'h51;
                7'h11: c = 7'h57;
                7'h12: c = 7'h45;
                7'h13: c = 7'h52;
                7'h14: c = 7'h54;
                7'h15: c = 7'h59;
                7'h16: c = 7'h55;
                7'h17: c = 7'h49;
                7'h18: c = 7'h4F;
                7'h19: c = 7'h50;
                7'h1A: c = 7'h7B;
                7'h1B: c = 7'h7D;
                7'h1C: c = 7'h0A;
                7'h1E: c = 7'h41;
                7'h1F: c = 7'h53;
                7'h20: c = 7'h44;
                7'h21: c = 7'h46;
                7'h22: c = 7'h47;
                7'h23: c = 7'h48;
                7'h24: c = 7'h4A;
                7'h25: c = 7'h4B;
                7'h26: c = 7'h4C;
                7'h27: c = 7'h3A;
                7'h28: c = 7'h22;
                7'h29: c = 7'h7E;
                7'h2B: c = 7'h7C;
                7'h2C: c = 7'h5A;
                7'h2D: c = 7'h58;
                7'h2E: c = 7'h43;
                7'h2F: c = 7'h56;
                7'h30: c = 7'h42;
                7'h31: c = 7'h4E;
                7'h32: c = 7'h4D;
                7'h33: c = 7'h3C;
                7'h34: c = 7'h3E;
                7'h35: c = 7'h3F;
                7'h37: c = 7'h2A;
                7'h39: c = 7'h20;
                default: c = 7'h00;
            endcase
            return c;
        end
    endfunction

endpackage

>>> rtl/ps2sc_in_if.sv
// Input channel: command and scancode words with a valid/ready handshake.
interface ps2sc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] scancode;

    modport source (output valid, output cmd, output scancode, input ready);
    modport sink   (input valid, input cmd, input scancode, output ready);
endinterface

>>> rtl/ps2sc_out_if.sv
// Output channel: decoded character and status words with a valid/ready handshake.
interface ps2sc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       char_valid;
    logic       buffer_empty;
    logic       buffer_full;
    logic       push_dropped;
    logic       shift_active;
    logic       caps_active;

    modport source (output valid, output character, output char_valid,
                    output buffer_empty, output buffer_full, output push_dropped,
                    output shift_active, output caps_active, input ready);
    modport sink   (input valid, input character, input char_valid,
                    input buffer_empty, input buffer_full, input push_dropped,
                    input shift_active, input caps_active, output ready);
endinterface

>>> rtl/ps2sc_out_queue.sv
// Small output word queue that decouples the decoder from a stalling receiver.
module ps2sc_out_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  ps2sc_pkg::result_t            push_word,
    output logic [ps2sc_pkg::OQ_CNT_W-1:0] count,
    ps2sc_out_if.source                   result
);

    ps2sc_pkg::result_t                 q_reg [ps2sc_pkg::OQ_DEPTH];
    logic [ps2sc_pkg::OQ_PTR_W-1:0]     wr_ptr_reg;
    logic [ps2sc_pkg::OQ_PTR_W-1:0]     rd_ptr_reg;
    logic [ps2sc_pkg::OQ_CNT_W-1:0]     count_reg;
    logic [ps2sc_pkg::OQ_CNT_W-1:0]     count_next;
    logic                               pop;
    ps2sc_pkg::result_t                 head;

    assign pop   = result.valid && result.ready;
    assign count = count_reg;
    assign head  = q_reg[rd_ptr_reg];

    assign result.valid        = (count_reg != '0);
    assign result.character    = head.character;
    assign result.char_valid   = head.char_valid;
    assign result.buffer_empty = head.buffer_empty;
    assign result.buffer_full  = head.buffer_full;
    assign result.push_dropped = head.push_dropped;
    assign result.shift_active = head.shift_active;
    assign result.caps_active  = head.caps_active;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

>>> rtl/ps2_scancode_to_ascii_fifo_top.sv
// Top level of the PS/2 set-1 scancode to ASCII decoder with its character FIFO.
//
// The scan channel takes one word per cycle while scan ready is high: a command and a scancode byte.
// A scancode command updates the shift and caps lock flags or looks the key
// up in the plain or shifted map and pushes a nonzero character into the
// character FIFO. Pop, flush and reinitialize commands act on the FIFO and
// the flags. Every accepted word yields exactly one word on the result
// channel, carrying the popped character and the status after that word.
//
// The character FIFO lives in a single memory with a registered read port,
// and holds FIFO_DEPTH-1 characters. A word is decoded when it is accepted;
// the read data and its status word are registered in the memory read stage,
// and the result is then written into a four-word output queue, from which it is offered.
// One word per cycle is sustained while the receiver
// takes results. When the receiver stalls, the output queue absorbs the
// words already in flight and scan ready drops once it would overflow.
// Reset clears the flags, the FIFO pointers and the output queue; the FIFO
// memory itself is not cleared, since only written entries are ever read.
module ps2_scancode_to_ascii_fifo_top #(
    parameter int FIFO_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    ps2sc_in_if.sink    scan,
    ps2sc_out_if.source result
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // Character FIFO storage.
    logic [6:0]         mem [FIFO_DEPTH];
    logic [6:0]         rd_data_reg;

    logic               shift_reg;
    logic               shift_next;
    logic               caps_reg;
    logic               caps_next;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;

    // Memory read stage: status word waiting for the read data.
    logic               p_valid_reg;
    ps2sc_pkg::result_t p_word_reg;
    ps2sc_pkg::result_t p_word_next;
    ps2sc_pkg::result_t q_word;

    logic [ps2sc_pkg::OQ_CNT_W-1:0] q_count;

    logic               accept;
    ps2sc_pkg::cmd_t    cmd;
    logic               released;
    logic [6:0]         key;
    logic [6:0]         lookup;
    logic               fifo_empty;
    logic               fifo_full;
    logic               do_push;
    logic               do_pop;
    logic               dropped;

    // Room is counted against the queue plus the word in the read stage.
    assign scan.ready = ({1'b0, q_count} + {{ps2sc_pkg::OQ_CNT_W{1'b0}}, p_valid_reg})
                        < (ps2sc_pkg::OQ_CNT_W + 1)'(ps2sc_pkg::OQ_DEPTH);
    assign accept     = scan.valid && scan.ready;

    assign cmd        = ps2sc_pkg::cmd_t'(scan.cmd);
    assign released   = scan.scancode[7];
    assign key        = scan.scancode[6:0];
    assign lookup     = (shift_reg ^ caps_reg) ? ps2sc_pkg::shift_char(key)
                                               : ps2sc_pkg::plain_char(key);
    assign fifo_empty = (wr_ptr_reg == rd_ptr_reg);
    assign fifo_full  = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);

    always_comb
    begin
        shift_next  = shift_reg;
        caps_next   = caps_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        dropped     = 1'b0;
        case (cmd)
            ps2sc_pkg::CMD_SCANCODE:
            begin
                if (key == ps2sc_pkg::KEY_LSHIFT || key == ps2sc_pkg::KEY_RSHIFT)
                begin
                    shift_next = !released;
                end
                else if (!released && key == ps2sc_pkg::KEY_CAPS)
                begin
                    caps_next = !caps_reg;
                end
                else if (!released && lookup != 7'h00)
                begin
                    if (fifo_full)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        do_push     = 1'b1;
                        wr_ptr_next = ptr_inc(wr_ptr_reg);
                    end
                end
            end
            ps2sc_pkg::CMD_POP:
            begin
                if (!fifo_empty)
                begin
                    do_pop      = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                end
            end
            ps2sc_pkg::CMD_FLUSH:
            begin
                wr_ptr_next = '0;
                rd_ptr_next = '0;
            end
            ps2sc_pkg::CMD_REINIT:
            begin
                shift_next  = 1'b0;
                caps_next   = 1'b0;
                wr_ptr_next = '0;
                rd_ptr_next = '0;
            end
            default:
            begin
                shift_next = shift_reg;
            end
        endcase

        p_word_next.character    = 7'h00;
        p_word_next.char_valid   = do_pop;
        p_word_next.buffer_empty = (wr_ptr_next == rd_ptr_next);
        p_word_next.buffer_full  = (ptr_inc(wr_ptr_next) == rd_ptr_next);
        p_word_next.push_dropped = dropped;
        p_word_next.shift_active = shift_next;
        p_word_next.caps_active  = caps_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg   <= 1'b0;
            caps_reg    <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= accept;
            if (accept)
            begin
                shift_reg  <= shift_next;
                caps_reg   <= caps_next;
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    // A push writes at the write pointer; a pop reads at the read pointer.
    // Both never happen for the same word, and a read that follows a write
    // to the same entry already sees the new data.
    always_ff @(posedge clk)
    begin
        if (accept && do_push)
        begin
            mem[wr_ptr_reg] <= lookup;
        end
        if (accept && do_pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
        if (accept)
        begin
            p_word_reg <= p_word_next;
        end
    end

    always_comb
    begin
        q_word           = p_word_reg;
        q_word.character = p_word_reg.char_valid ? rd_data_reg : 7'h00;
    end

    ps2sc_out_queue u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (p_valid_reg),
        .push_word (q_word),
        .count     (q_count),
        .result    (result)
    );

endmodule

>>> dv/tb_top.sv
// Testbench for the PS/2 set-1 scancode to ASCII decoder with its character FIFO.
`timescale 1ns / 100ps

module tb_top;

    localparam int FIFO_DEPTH  = 256;
    localparam int KEY_WORDS   = 900;
    localparam int IDLE_PCT    = 18;
    // Both sides stay busy through this window of cycles.
    localparam int QUIET_FIRST = 400;
    localparam int QUIET_LAST  = 800;

    typedef struct {
        ps2sc_pkg::cmd_t cmd;
        logic [7:0]      code;
        bit              drain;   // hold this word back until every result is in
    } key_word_t;

    logic clk = 1'b0;
    logic rst_n;

    ps2sc_in_if  scan_ch ();
    ps2sc_out_if result_ch ();

    ps2_scancode_to_ascii_fifo_top #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan_ch),
        .result(result_ch)
    );

    always #10 clk = ~clk;

    // Key maps of the predictor, filled before reset is released.
    logic [6:0] plain_map [128];
    logic [6:0] shift_map [128];

    // Predicted keyboard and FIFO state.
    bit         kb_shift;
    bit         kb_caps;
    logic [6:0] char_ring [FIFO_DEPTH];
    int         ring_wr;
    int         ring_rd;

    key_word_t           key_words_q[$];
    ps2sc_pkg::result_t  decoded_q[$];

    int unsigned cyc;
    int          n_sent;
    int          n_checked;
    bit          failed;
    bit          quiet;

    assign quiet = (cyc >= QUIET_FIRST) && (cyc < QUIET_LAST);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
        end
    end

    // Copies a run of printable characters into both maps, starting at one key.
    task automatic put_span(input int first, input string plain_s, input string shift_s);
        begin
            for (int i = 0; i < plain_s.len(); i++)
            begin
                plain_map[first + i] = 7'(plain_s[i]);
                shift_map[first + i] = 7'(shift_s[i]);
            end
        end
    endtask

    task automatic put_key(input int key, input logic [6:0] plain_c, input logic [6:0] shift_c);
        begin
            plain_map[key] = plain_c;
            shift_map[key] = shift_c;
        end
    endtask

    task automatic build_key_maps();
        begin
            for (int k = 0; k < 128; k++)
            begin
                plain_map[k] = 7'h00;
                shift_map[k] = 7'h00;
            end
            put_key(8'h01, 7'h1B, 7'h1B);   // escape
            put_span(8'h02, "1234567890-=", "!@#$%^&*()_+");
            put_key(8'h0E, 7'h08, 7'h08);   // backspace
            put_key(8'h0F, 7'h09, 7'h09);   // tab
            put_span(8'h10, "qwertyuiop[]", "QWERTYUIOP{}");
            put_key(8'h1C, 7'h0A, 7'h0A);   // enter
            put_span(8'h1E, "asdfghjkl;'", "ASDFGHJKL:\"");
            put_key(8'h29, 7'h60, 7'h7E);   // grave accent and tilde
            put_span(8'h2B, "\\zxcvbnm,./", "|ZXCVBNM<>?");
            put_key(8'h37, 7'h2A, 7'h2A);   // keypad star
            put_key(8'h39, 7'h20, 7'h20);   // space
        end
    endtask

    function automatic int ring_next(input int p);
        begin
            return (p + 1 >= FIFO_DEPTH) ? 0 : p + 1;
        end
    endfunction

    // Applies one accepted word to the predicted state and returns the status
    // word the block must answer with.
    function automatic ps2sc_pkg::result_t decode_key_word(input ps2sc_pkg::cmd_t cmd,
                                                           input logic [7:0] code);
        ps2sc_pkg::result_t r;
        logic [6:0]         key;
        logic [6:0]         c;
        bit                 released;
        begin
            r = '0;
            key = code[6:0];
            released = code[7];
            case (cmd)
                ps2sc_pkg::CMD_SCANCODE:
                begin
                    if (key == ps2sc_pkg::KEY_LSHIFT || key == ps2sc_pkg::KEY_RSHIFT)
                    begin
                        kb_shift = !released;
                    end
                    else if (!released && key == ps2sc_pkg::KEY_CAPS)
                    begin
                        kb_caps = !kb_caps;
                    end
                    else if (!released)
                    begin
                        // Shift XOR caps picks the map for every key, digits included.
                        c = (kb_shift != kb_caps) ? shift_map[key] : plain_map[key];
                        if (c != 7'h00)
                        begin
                            if (ring_next(ring_wr) == ring_rd)
                            begin
                                r.push_dropped = 1'b1;
                            end
                            else
                            begin
                                char_ring[ring_wr] = c;
                                ring_wr = ring_next(ring_wr);
                            end
                        end
                    end
                end
                ps2sc_pkg::CMD_POP:
                begin
                    if (ring_wr != ring_rd)
                    begin
                        r.character = char_ring[ring_rd];
                        r.char_valid = 1'b1;
                        ring_rd = ring_next(ring_rd);
                    end
                end
                ps2sc_pkg::CMD_FLUSH:
                begin
                    ring_wr = 0;
                    ring_rd = 0;
                end
                default:
                begin
                    kb_shift = 1'b0;
                    kb_caps = 1'b0;
                    ring_wr = 0;
                    ring_rd = 0;
                end
            endcase
            r.buffer_empty = (ring_wr == ring_rd);
            r.buffer_full = (ring_next(ring_wr) == ring_rd);
            r.shift_active = kb_shift;
            r.caps_active = kb_caps;
            return r;
        end
    endfunction

    // Driver: offers queued words, idling at random outside the quiet window.
    // A word marked for draining waits until every earlier result is back.
    always @(posedge clk or negedge rst_n)
    begin : drive
        key_word_t w;
        bit        go;
        if (!rst_n)
        begin
            scan_ch.valid <= 1'b0;
            scan_ch.cmd <= ps2sc_pkg::CMD_SCANCODE;
            scan_ch.scancode <= 8'h00;
            n_sent <= 0;
        end
        else
        begin
            if (scan_ch.valid && scan_ch.ready)
            begin
                decoded_q.push_back(decode_key_word(ps2sc_pkg::cmd_t'(scan_ch.cmd),
                                                    scan_ch.scancode));
                n_sent <= n_sent + 1;
            end
            if (!scan_ch.valid || scan_ch.ready)
            begin
                go = (key_words_q.size() != 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
                if (go && key_words_q[0].drain && (scan_ch.valid || n_sent != n_checked))
                begin
                    go = 1'b0;
                end
                if (go)
                begin
                    w = key_words_q.pop_front();
                    scan_ch.valid <= 1'b1;
                    scan_ch.cmd <= w.cmd;
                    scan_ch.scancode <= w.code;
                end
                else
                begin
                    scan_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        begin
            if (want != got)
            begin
                failed = 1'b1;
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        end
    endtask

    // Monitor: takes result words, stalling at random, and checks each one
    // against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : watch
        ps2sc_pkg::result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            n_checked <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    failed = 1'b1;
                    $error("result word arrived with no prediction waiting");
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("character", want.character, result_ch.character);
                    check_field("char_valid", want.char_valid, result_ch.char_valid);
                    check_field("buffer_empty", want.buffer_empty, result_ch.buffer_empty);
                    check_field("buffer_full", want.buffer_full, result_ch.buffer_full);
                    check_field("push_dropped", want.push_dropped, result_ch.push_dropped);
                    check_field("shift_active", want.shift_active, result_ch.shift_active);
                    check_field("caps_active", want.caps_active, result_ch.caps_active);
                end
                n_checked <= n_checked + 1;
            end
            result_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic add_word(input ps2sc_pkg::cmd_t cmd, input logic [7:0] code,
                            input bit drain = 1'b0);
        key_word_t w;
        begin
            w.cmd = cmd;
            w.code = code;
            w.drain = drain;
            key_words_q.push_back(w);
        end
    endtask

    // A random key that produces a character in the plain map.
    function automatic logic [7:0] char_key();
        logic [6:0] k;
        begin
            do
            begin
                k = 7'($urandom_range(8'h01, 8'h39));
            end
            while (plain_map[k] == 7'h00);
            return {1'b0, k};
        end
    endfunction

    // Typing burst: mostly character presses, with shift, caps lock and key
    // releases mixed in, and now and then an arbitrary byte.
    task automatic add_typing();
        int n;
        int r;
        begin
            n = $urandom_range(3, 12);
            for (int i = 0; i < n; i++)
            begin
                r = $urandom_range(99);
                if (r < 60)
                begin
                    add_word(ps2sc_pkg::CMD_SCANCODE, char_key());
                end
                else if (r < 70)
                begin
                    add_word(ps2sc_pkg::CMD_SCANCODE, {1'($urandom_range(1)),
                             (($urandom_range(1) != 0) ? ps2sc_pkg::KEY_LSHIFT
                                                       : ps2sc_pkg::KEY_RSHIFT)});
                end
                else if (r < 75)
                begin
                    add_word(ps2sc_pkg::CMD_SCANCODE,
                             {1'($urandom_range(99) < 25), ps2sc_pkg::KEY_CAPS});
                end
                else if (r < 85)
                begin
                    add_word(ps2sc_pkg::CMD_SCANCODE, {1'b1, 7'($urandom_range(127))});
                end
                else
                begin
                    add_word(ps2sc_pkg::CMD_SCANCODE, 8'($urandom_range(255)));
                end
            end
        end
    endtask

    initial
    begin : stimulus
        int r;
        int n;
        // Every block input is known from time zero, before reset takes effect.
        rst_n = 1'b0;
        scan_ch.valid = 1'b0;
        scan_ch.cmd = ps2sc_pkg::CMD_SCANCODE;
        scan_ch.scancode = 8'h00;
        result_ch.ready = 1'b0;
        kb_shift = 1'b0;
        kb_caps = 1'b0;
        ring_wr = 0;
        ring_rd = 0;
        failed = 1'b0;
        build_key_maps();

        // Directed words: pop on an empty FIFO, both shift keys, caps lock
        // press and release, shift XOR caps on letters and digits, releases
        // that do nothing, keys with no character, flush and reinitialize.
        add_word(ps2sc_pkg::CMD_POP, 8'hFF);
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h1E);
        add_word(ps2sc_pkg::CMD_SCANCODE, {1'b0, ps2sc_pkg::KEY_LSHIFT});
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h1E);
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h02);
        add_word(ps2sc_pkg::CMD_SCANCODE, {1'b1, ps2sc_pkg::KEY_LSHIFT});
        add_word(ps2sc_pkg::CMD_SCANCODE, {1'b0, ps2sc_pkg::KEY_CAPS});
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h02);
        add_word(ps2sc_pkg::CMD_SCANCODE, {1'b0, ps2sc_pkg::KEY_RSHIFT});
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h1E);
        add_word(ps2sc_pkg::CMD_SCANCODE, {1'b1, ps2sc_pkg::KEY_RSHIFT});
        add_word(ps2sc_pkg::CMD_SCANCODE, {1'b1, ps2sc_pkg::KEY_CAPS});
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h9E);
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h00);
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h7F);
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h1D);
        add_word(ps2sc_pkg::CMD_SCANCODE, {1'b0, ps2sc_pkg::KEY_CAPS});
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h39);
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h37);
        add_word(ps2sc_pkg::CMD_POP, 8'h00);
        add_word(ps2sc_pkg::CMD_POP, 8'h80);
        add_word(ps2sc_pkg::CMD_FLUSH, 8'hA5);
        add_word(ps2sc_pkg::CMD_POP, 8'h5A);
        add_word(ps2sc_pkg::CMD_SCANCODE, {1'b0, ps2sc_pkg::KEY_LSHIFT});
        add_word(ps2sc_pkg::CMD_SCANCODE, {1'b0, ps2sc_pkg::KEY_CAPS});
        add_word(ps2sc_pkg::CMD_REINIT, 8'h3C);
        add_word(ps2sc_pkg::CMD_SCANCODE, 8'h80);

        // Fill the FIFO past its capacity from a clean start so that the
        // full flag and dropped pushes show up; the random traffic after it
        // drains the backlog slowly.
        add_word(ps2sc_pkg::CMD_FLUSH, 8'($urandom_range(255)), 1'b1);
        for (int i = 0; i < FIFO_DEPTH + 2; i++)
        begin
            add_word(ps2sc_pkg::CMD_SCANCODE, char_key());
        end

        while (key_words_q.size() < KEY_WORDS)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                add_typing();
            end
            else if (r < 80)
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                begin
                    add_word(ps2sc_pkg::CMD_POP, 8'($urandom_range(255)));
                end
            end
            else if (r < 85)
            begin
                add_word(ps2sc_pkg::CMD_FLUSH, 8'($urandom_range(255)));
            end
            else if (r < 88)
            begin
                add_word(ps2sc_pkg::CMD_REINIT, 8'($urandom_range(255)), 1'b1);
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    add_word(ps2sc_pkg::cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
                end
            end
        end
        n = key_words_q.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // All words accepted, then all results back, then a short settle
        // so that any stray extra result word is caught by the monitor.
        wait (n_sent == n);
        wait (n_checked >= n_sent);
        repeat (20) @(posedge clk);
        if (!failed && decoded_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2ms;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ps2sc_pkg.sv
rtl/ps2sc_in_if.sv
rtl/ps2sc_out_if.sv
rtl/ps2sc_out_queue.sv
rtl/ps2_scancode_to_ascii_fifo_top.sv
dv/tb_top.sv
